[sv/pgs_pkg.sv]
// ----------------------------------------------------------------------------
// PCM gain and saturation package
// Shared types, register indexes, format codes and byte-swap helpers.
// ----------------------------------------------------------------------------
package pgs_pkg;

  localparam int DATA_W         = 32;
  localparam int GAIN_W         = 32;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int SAMPLE_BITS    = 32;
  localparam int FMT_W          = 3;
  localparam int REG_IDX_W      = 3;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SWAP_BYTES    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_LINEAR   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_ENABLE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_ENABLE   = 3'd4;

  localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S8  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_U16 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_S16 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_U32 = 3'd4;
  localparam logic [FMT_W-1:0] FMT_S32 = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0100_0000;
  localparam logic [GAIN_W-1:0] GAIN_UNITY =
    {{(GAIN_W-GAIN_FRAC_BITS-1){1'b0}}, 1'b1, {GAIN_FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [DATA_W-1:0] sample_in;
    logic              end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample_out;
    logic              end_of_buffer_out;
  } out_item_t;

  typedef struct packed {
    logic [FMT_W-1:0]  sample_format;
    logic              swap_bytes;
    logic [GAIN_W-1:0] gain_linear;
    logic              limit_enable;
    logic              gain_enable;
  } cfg_t;

  function automatic logic [15:0] swap16(logic [15:0] x);
    return {x[7:0], x[15:8]};
  endfunction

  function automatic logic [31:0] swap32(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

[sv/pgs_pipe.sv]
// ----------------------------------------------------------------------------
// PCM gain pipeline
// Four register stages: operand prep, multiply, re-bias and shift, clamp.
// ----------------------------------------------------------------------------
module pgs_pipe (
  input  logic              clk,
  input  logic              rst,
  input  pgs_pkg::cfg_t     cfg,
  input  logic              start,
  input  pgs_pkg::in_item_t item,
  output logic              done,
  output pgs_pkg::out_item_t result
);
  import pgs_pkg::*;

  localparam int SW = SAMPLE_BITS;
  localparam int PW = SW + GAIN_W;
  localparam int TW = PW + 1;
  localparam int QW = TW - GAIN_FRAC_BITS;

  localparam logic [1:0] W_8    = 2'd0;
  localparam logic [1:0] W_16   = 2'd1;
  localparam logic [1:0] W_FULL = 2'd2;

  typedef struct packed {
    logic              neg;
    logic              is_signed;
    logic [1:0]        wsel;
    logic              sw;
    logic              bypass;
    logic [DATA_W-1:0] raw;
    logic              eob;
  } ctl_t;

  function automatic logic [SW-1:0] wmask(logic [1:0] wsel);
    unique case (wsel)
      W_8:     return SW'(8'hFF);
      W_16:    return SW'(16'hFFFF);
      default: return '1;
    endcase
  endfunction

  // Stage 1: operand preparation.
  logic [GAIN_W-1:0] g_eff;
  logic [DATA_W-1:0] v;
  logic [SW-1:0]     mask1, half1, sb1, x1, op_next;
  ctl_t              ctl_next;

  always_comb begin
    g_eff = (cfg.limit_enable && cfg.gain_linear > GAIN_UNITY) ? GAIN_UNITY
                                                               : cfg.gain_linear;
    ctl_next.raw       = item.sample_in;
    ctl_next.eob       = item.end_of_buffer;
    ctl_next.is_signed = cfg.sample_format[0];
    ctl_next.bypass    = !cfg.gain_enable || g_eff == GAIN_UNITY ||
                         cfg.sample_format > FMT_S32;
    unique case (cfg.sample_format)
      FMT_U8, FMT_S8:   ctl_next.wsel = W_8;
      FMT_U16, FMT_S16: ctl_next.wsel = W_16;
      default:          ctl_next.wsel = W_FULL;
    endcase
    ctl_next.sw = cfg.swap_bytes && ctl_next.wsel != W_8;
    if (!ctl_next.sw) begin
      v = item.sample_in;
    end else if (ctl_next.wsel == W_16) begin
      v = {16'b0, swap16(item.sample_in[15:0])};
    end else begin
      v = swap32(item.sample_in);
    end
    mask1 = wmask(ctl_next.wsel);
    half1 = mask1 >> 1;
    sb1   = half1 + SW'(1);
    x1    = v[SW-1:0] & mask1;
    if (ctl_next.is_signed) begin
      ctl_next.neg = |(x1 & sb1);
      op_next      = ctl_next.neg ? (mask1 - x1 + SW'(1)) : x1;
    end else begin
      ctl_next.neg = x1 < half1;
      op_next      = ctl_next.neg ? (half1 - x1) : (x1 - half1);
    end
  end

  logic              v1, v2, v3, v4;
  ctl_t              ctl1, ctl2, ctl3;
  logic [SW-1:0]     op1;
  logic [GAIN_W-1:0] g1;
  logic [PW-1:0]     prod2;
  logic [QW-1:0]     q3;
  out_item_t         res4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ctl1 <= ctl_next;
    op1  <= op_next;
    g1   <= g_eff;
  end

  // Stage 2: multiply.
  always_ff @(posedge clk) begin
    ctl2  <= ctl1;
    prod2 <= PW'(op1) * PW'(g1);
  end

  // Stage 3: re-bias for unsigned formats and drop the fraction.
  logic [SW-1:0] half3;
  logic [TW-1:0] prod_x, bias, t;

  always_comb begin
    half3  = wmask(ctl2.wsel) >> 1;
    prod_x = {1'b0, prod2};
    bias   = TW'(half3) << GAIN_FRAC_BITS;
    if (ctl2.is_signed) begin
      t = prod_x;
    end else if (!ctl2.neg) begin
      t = prod_x + bias;
    end else if (prod_x >= bias) begin
      t = '0;
    end else begin
      t = bias - prod_x;
    end
  end

  always_ff @(posedge clk) begin
    ctl3 <= ctl2;
    q3   <= t[TW-1:GAIN_FRAC_BITS];
  end

  // Stage 4: clamp, restore sign, swap back.
  logic [SW-1:0]     mask4, half4, r;
  logic [QW-1:0]     mask_q, sb_q, qc, neg_q;
  logic [DATA_W-1:0] res;

  always_comb begin
    mask4  = wmask(ctl3.wsel);
    half4  = mask4 >> 1;
    mask_q = QW'(mask4);
    sb_q   = QW'(half4) + QW'(1);
    qc     = q3;
    neg_q  = '0;
    if (ctl3.is_signed && ctl3.neg) begin
      qc    = (q3 > sb_q) ? sb_q : q3;
      neg_q = QW'(0) - qc;
      r     = neg_q[SW-1:0] & mask4;
    end else if (ctl3.is_signed) begin
      qc = (q3 > sb_q - QW'(1)) ? sb_q - QW'(1) : q3;
      r  = qc[SW-1:0];
    end else begin
      r = (q3 > mask_q) ? mask4 : q3[SW-1:0];
    end
    res = DATA_W'(r);
    if (ctl3.sw) begin
      res = (ctl3.wsel == W_16) ? {16'b0, swap16(res[15:0])} : swap32(res);
    end
    if (ctl3.bypass) begin
      res = ctl3.raw;
    end
  end

  always_ff @(posedge clk) begin
    res4.sample_out        <= res;
    res4.end_of_buffer_out <= ctl3.eob;
  end

  assign done   = v4;
  assign result = res4;

endmodule

[sv/pcm_gain_saturate_top.sv]
// ----------------------------------------------------------------------------
// PCM gain with saturation, top level
// Configuration registers and the gain pipeline.
// ----------------------------------------------------------------------------
// The block takes one sample in every cycle and never stalls: busy is always
// low, and each item's result appears on result with done high once it has
// passed the four register stages of the pipeline (prep, multiply, re-bias,
// clamp). The receiver cannot hold results off, so done must be taken in the
// cycle it is shown. Registers may be written only while no item is in
// flight.
module pcm_gain_saturate_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pgs_pkg::in_item_t              item,
  output logic                           done,
  output pgs_pkg::out_item_t             result,
  input  logic                           cfg_we,
  input  logic [pgs_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [pgs_pkg::GAIN_W-1:0]     cfg_data
);
  import pgs_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_format <= FMT_S16;
      cfg.swap_bytes    <= 1'b0;
      cfg.gain_linear   <= GAIN_RESET;
      cfg.limit_enable  <= 1'b0;
      cfg.gain_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_FORMAT: cfg.sample_format <= cfg_data[FMT_W-1:0];
        REG_SWAP_BYTES:    cfg.swap_bytes    <= cfg_data[0];
        REG_GAIN_LINEAR:   cfg.gain_linear   <= cfg_data;
        REG_LIMIT_ENABLE:  cfg.limit_enable  <= cfg_data[0];
        REG_GAIN_ENABLE:   cfg.gain_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  pgs_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .start  (start),
    .item   (item),
    .done   (done),
    .result (result)
  );

endmodule
